FILE: hw/rtl/kaf_pkg.sv
// ----------------------------------------------------------------------------
// kaf_pkg
// shared types, codes, constants and the micro-program of the angle filter
// ----------------------------------------------------------------------------
package kaf_pkg;

  localparam logic signed [31:0] S32_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN  = 32'sh8000_0000;
  localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;

  // configuration register indexes
  localparam logic [3:0] CFG_ANGLE_NOISE   = 4'd0;
  localparam logic [3:0] CFG_BIAS_NOISE    = 4'd1;
  localparam logic [3:0] CFG_MEASURE_NOISE = 4'd2;
  localparam logic [3:0] CFG_STEP_TIME     = 4'd3;

  // configuration reset values, q2.30
  localparam logic [30:0] ANGLE_NOISE_RST   = 31'd1073742;
  localparam logic [30:0] BIAS_NOISE_RST    = 31'd3221225;
  localparam logic [30:0] MEASURE_NOISE_RST = 31'd32212255;
  localparam logic [30:0] STEP_TIME_RST     = 31'd10737418;

  typedef struct packed {
    logic signed [31:0] measured_angle;
    logic signed [31:0] measured_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] filtered_angle;
    logic signed [31:0] bias_estimate;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL1,
    ST_MUL2,
    ST_DIV
  } state_t;

  typedef enum logic [1:0] {
    K_ALU,
    K_MAC,
    K_DIV,
    K_END
  } kind_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_BRK,
    OP_PASS
  } op_t;

  typedef enum logic [4:0] {
    SRC_MANG,
    SRC_MRATE,
    SRC_ANG,
    SRC_BIAS,
    SRC_PAA,
    SRC_PAB,
    SRC_PBA,
    SRC_PBB,
    SRC_RATE,
    SRC_DP,
    SRC_T,
    SRC_K0,
    SRC_K1,
    SRC_Y,
    SRC_DT,
    SRC_QA,
    SRC_QB,
    SRC_MUL
  } src_t;

  typedef struct packed {
    kind_t kind;
    src_t  ma;
    src_t  mb;
    op_t   op;
    src_t  x;
    src_t  y;
    src_t  dest;
  } uop_t;

  localparam int PC_W = 5;

  // saturate a 35-bit signed value to 32 bits
  function automatic logic signed [31:0] sat_s32(input logic signed [34:0] v);
    logic signed [31:0] res;
    if (v > 35'sd2147483647) begin
      res = S32_MAX;
    end else if (v < -35'sd2147483648) begin
      res = S32_MIN;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic uop_t mk(input kind_t k, input src_t ma, input src_t mb, input op_t op,
                              input src_t x, input src_t y, input src_t dest);
    uop_t u;
    u.kind = k;
    u.ma   = ma;
    u.mb   = mb;
    u.op   = op;
    u.x    = x;
    u.y    = y;
    u.dest = dest;
    return u;
  endfunction

  // predict, gain, correct
  function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      5'd0:  u = mk(K_ALU, SRC_DT, SRC_DT,   OP_SUB,  SRC_MRATE, SRC_BIAS, SRC_RATE);
      5'd1:  u = mk(K_MAC, SRC_DT, SRC_RATE, OP_ADD,  SRC_ANG,   SRC_MUL,  SRC_ANG);
      5'd2:  u = mk(K_MAC, SRC_DT, SRC_PBB,  OP_PASS, SRC_DP,    SRC_MUL,  SRC_DP);
      5'd3:  u = mk(K_ALU, SRC_DT, SRC_DT,   OP_BRK,  SRC_DP,    SRC_DP,   SRC_T);
      5'd4:  u = mk(K_MAC, SRC_DT, SRC_T,    OP_ADD,  SRC_PAA,   SRC_MUL,  SRC_PAA);
      5'd5:  u = mk(K_ALU, SRC_DT, SRC_DT,   OP_SUB,  SRC_PAB,   SRC_DP,   SRC_PAB);
      5'd6:  u = mk(K_ALU, SRC_DT, SRC_DT,   OP_SUB,  SRC_PBA,   SRC_DP,   SRC_PBA);
      5'd7:  u = mk(K_MAC, SRC_QB, SRC_DT,   OP_ADD,  SRC_PBB,   SRC_MUL,  SRC_PBB);
      5'd8:  u = mk(K_DIV, SRC_DT, SRC_DT,   OP_PASS, SRC_PAA,   SRC_PAA,  SRC_K0);
      5'd9:  u = mk(K_DIV, SRC_DT, SRC_DT,   OP_PASS, SRC_PBA,   SRC_PBA,  SRC_K1);
      5'd10: u = mk(K_ALU, SRC_DT, SRC_DT,   OP_SUB,  SRC_MANG,  SRC_ANG,  SRC_Y);
      5'd11: u = mk(K_MAC, SRC_K0, SRC_Y,    OP_ADD,  SRC_ANG,   SRC_MUL,  SRC_ANG);
      5'd12: u = mk(K_MAC, SRC_K1, SRC_Y,    OP_ADD,  SRC_BIAS,  SRC_MUL,  SRC_BIAS);
      5'd13: u = mk(K_MAC, SRC_K1, SRC_PAB,  OP_SUB,  SRC_PBB,   SRC_MUL,  SRC_PBB);
      5'd14: u = mk(K_MAC, SRC_K0, SRC_PAB,  OP_SUB,  SRC_PAB,   SRC_MUL,  SRC_PAB);
      5'd15: u = mk(K_MAC, SRC_K1, SRC_PAA,  OP_SUB,  SRC_PBA,   SRC_MUL,  SRC_PBA);
      5'd16: u = mk(K_MAC, SRC_K0, SRC_PAA,  OP_SUB,  SRC_PAA,   SRC_MUL,  SRC_PAA);
      default: u = mk(K_END, SRC_DT, SRC_DT, OP_PASS, SRC_ANG,   SRC_ANG,  SRC_ANG);
    endcase
    return u;
  endfunction

endpackage

FILE: hw/rtl/kaf_mulq.sv
// ----------------------------------------------------------------------------
// kaf_mulq
// shared q2.30 multiplier: product, round half up, saturate, two stages
// ----------------------------------------------------------------------------
module kaf_mulq (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [31:0] res
);

  logic signed [63:0] p_r;
  logic signed [63:0] v;
  logic signed [31:0] m_r;

  assign v = p_r + kaf_pkg::HALF_Q30;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
    end
    m_r <= kaf_pkg::sat_s32({v[63], v[63:30]});
  end

  assign res = m_r;

endmodule

FILE: hw/rtl/kaf_div.sv
// ----------------------------------------------------------------------------
// kaf_div
// gain divider: (num * 2^30) / den, truncated, saturated, zero for a zero den, one bit a cycle
// ----------------------------------------------------------------------------
module kaf_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [32:0] den,
  output logic               done,
  output logic signed [31:0] quot
);

  logic        busy_r;
  logic        fin_r;
  logic [4:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] lo_r;
  logic [31:0] q_r;
  logic [31:0] dmag_r;
  logic        neg_r;
  logic        ovf_r;
  logic        zero_r;

  logic [31:0] nmag;
  logic [32:0] dneg;
  logic [31:0] dmag;
  logic [31:0] hi;
  logic        den_zero;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    nmag     = num[31] ? (~num + 32'd1) : num;
    dneg     = ~den + 33'd1;
    dmag     = den[32] ? dneg[31:0] : den[31:0];
    hi       = {2'b00, nmag[31:2]};
    den_zero = (den == 33'sd0);
    trial    = {rem_r, lo_r[31]};
    diff     = trial - {1'b0, dmag_r};
    ge       = (trial >= {1'b0, dmag_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      fin_r <= 1'b0;
      if (start) begin
        rem_r  <= hi;
        lo_r   <= {nmag[1:0], 30'd0};
        q_r    <= 32'd0;
        dmag_r <= dmag;
        cnt_r  <= 5'd31;
        neg_r  <= num[31] ^ den[32];
        zero_r <= den_zero;
        ovf_r  <= !den_zero && (hi >= dmag);
        if (den_zero || (hi >= dmag)) begin
          fin_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= ge ? diff[31:0] : trial[31:0];
        q_r   <= {q_r[30:0], ge};
        lo_r  <= {lo_r[30:0], 1'b0};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (zero_r) begin
      quot = 32'sd0;
    end else if (ovf_r) begin
      quot = neg_r ? kaf_pkg::S32_MIN : kaf_pkg::S32_MAX;
    end else if (neg_r) begin
      quot = (q_r > 32'h8000_0000) ? kaf_pkg::S32_MIN : $signed(~q_r + 32'd1);
    end else begin
      quot = q_r[31] ? kaf_pkg::S32_MAX : $signed(q_r);
    end
  end

  assign done = fin_r;

endmodule

FILE: hw/rtl/kalman_angle_filter_unit.sv
// ----------------------------------------------------------------------------
// kalman_angle_filter_unit
// two-state angle and bias kalman filter on a shared multiplier and divider
// ----------------------------------------------------------------------------
// work per item: set by the two gain divisions (one quotient bit a cycle)
//   plus ten multiply-accumulate steps; a division ends at once when its
//   denominator is zero or its quotient does not fit in 32 bits
// input: a new item is taken while the previous result still waits in
//   the output register, but not before the current item is done
// reset: synchronous active low; estimates and covariance clear to zero,
//   noise and step time registers load their defaults
// ----------------------------------------------------------------------------
module kalman_angle_filter_unit (
  input  logic                clk,
  input  logic                rst_n,
  // input items
  input  logic                in_valid,
  output logic                in_ready,
  input  kaf_pkg::in_item_t   in_data,
  // result items
  output logic                out_valid,
  input  logic                out_ready,
  output kaf_pkg::out_item_t  out_data,
  // configuration
  input  logic                cfg_we,
  input  logic [3:0]          cfg_index,
  input  logic [30:0]         cfg_wdata
);

  // sequencer
  kaf_pkg::state_t             state_r, state_nxt;
  logic [kaf_pkg::PC_W-1:0]    pc_r, pc_nxt;
  kaf_pkg::uop_t               uop;

  // configuration registers
  logic [30:0] qa_r;
  logic [30:0] qb_r;
  logic [30:0] rn_r;
  logic [30:0] dt_r;

  // filter state
  logic signed [31:0] ang_r;
  logic signed [31:0] bias_r;
  logic signed [31:0] paa_r;
  logic signed [31:0] pab_r;
  logic signed [31:0] pba_r;
  logic signed [31:0] pbb_r;

  // per-item scratch
  logic signed [31:0] mang_r;
  logic signed [31:0] mrate_r;
  logic signed [31:0] rate_r;
  logic signed [31:0] dp_r;
  logic signed [31:0] t_r;
  logic signed [31:0] k0_r;
  logic signed [31:0] k1_r;
  logic signed [31:0] y_r;

  // output register
  logic                out_valid_r;
  kaf_pkg::out_item_t  out_data_r;

  // control
  logic mul_en;
  logic div_start;
  logic wr_en;
  logic wr_div;
  logic out_load;
  logic accept;

  // datapath
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [31:0] mul_res;
  logic signed [31:0] alu_x;
  logic signed [31:0] alu_y;
  logic signed [34:0] alu_sum;
  logic signed [31:0] alu_res;
  logic signed [31:0] wdata;
  logic signed [32:0] div_den;
  logic               div_done;
  logic signed [31:0] div_quot;

  assign uop    = kaf_pkg::uop_rom(pc_r);
  assign accept = in_valid && in_ready;

  // operand select shared by the multiplier and alu ports
  function automatic logic signed [31:0] pick(input kaf_pkg::src_t s);
    logic signed [31:0] v;
    case (s)
      kaf_pkg::SRC_MANG:  v = mang_r;
      kaf_pkg::SRC_MRATE: v = mrate_r;
      kaf_pkg::SRC_ANG:   v = ang_r;
      kaf_pkg::SRC_BIAS:  v = bias_r;
      kaf_pkg::SRC_PAA:   v = paa_r;
      kaf_pkg::SRC_PAB:   v = pab_r;
      kaf_pkg::SRC_PBA:   v = pba_r;
      kaf_pkg::SRC_PBB:   v = pbb_r;
      kaf_pkg::SRC_RATE:  v = rate_r;
      kaf_pkg::SRC_DP:    v = dp_r;
      kaf_pkg::SRC_T:     v = t_r;
      kaf_pkg::SRC_K0:    v = k0_r;
      kaf_pkg::SRC_K1:    v = k1_r;
      kaf_pkg::SRC_Y:     v = y_r;
      kaf_pkg::SRC_DT:    v = $signed({1'b0, dt_r});
      kaf_pkg::SRC_QA:    v = $signed({1'b0, qa_r});
      kaf_pkg::SRC_QB:    v = $signed({1'b0, qb_r});
      kaf_pkg::SRC_MUL:   v = mul_res;
      default:            v = 32'sd0;
    endcase
    return v;
  endfunction

  // next state and program counter
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    case (state_r)
      kaf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = kaf_pkg::ST_EXEC;
          pc_nxt    = '0;
        end
      end
      kaf_pkg::ST_EXEC: begin
        case (uop.kind)
          kaf_pkg::K_ALU: pc_nxt = pc_r + 1'b1;
          kaf_pkg::K_MAC: state_nxt = kaf_pkg::ST_MUL1;
          kaf_pkg::K_DIV: state_nxt = kaf_pkg::ST_DIV;
          kaf_pkg::K_END: begin
            // wait here while the previous result is still held
            if (!out_valid_r || out_ready) begin
              state_nxt = kaf_pkg::ST_IDLE;
            end
          end
          default: state_nxt = kaf_pkg::ST_IDLE;
        endcase
      end
      kaf_pkg::ST_MUL1: state_nxt = kaf_pkg::ST_MUL2;
      kaf_pkg::ST_MUL2: begin
        state_nxt = kaf_pkg::ST_EXEC;
        pc_nxt    = pc_r + 1'b1;
      end
      kaf_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = kaf_pkg::ST_EXEC;
          pc_nxt    = pc_r + 1'b1;
        end
      end
      default: state_nxt = kaf_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    mul_en    = 1'b0;
    div_start = 1'b0;
    wr_en     = 1'b0;
    wr_div    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      kaf_pkg::ST_IDLE: in_ready = 1'b1;
      kaf_pkg::ST_EXEC: begin
        case (uop.kind)
          kaf_pkg::K_ALU: wr_en     = 1'b1;
          kaf_pkg::K_MAC: mul_en    = 1'b1;
          kaf_pkg::K_DIV: div_start = 1'b1;
          kaf_pkg::K_END: out_load  = !out_valid_r || out_ready;
          default: ;
        endcase
      end
      kaf_pkg::ST_MUL2: begin
        // product is rounded now, add, subtract or pass it into the destination
        wr_en = 1'b1;
      end
      kaf_pkg::ST_DIV: begin
        if (div_done) begin
          wr_en  = 1'b1;
          wr_div = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // operands
  always_comb begin
    mul_a = pick(uop.ma);
    mul_b = pick(uop.mb);
    alu_x = pick(uop.x);
    alu_y = pick(uop.y);
  end

  // alu: exact sum in 35 bits, then saturate once
  always_comb begin
    case (uop.op)
      kaf_pkg::OP_ADD: alu_sum = 35'(alu_x) + 35'(alu_y);
      kaf_pkg::OP_SUB: alu_sum = 35'(alu_x) - 35'(alu_y);
      // bracket term dt*pbb - pab - pba + qa
      kaf_pkg::OP_BRK: alu_sum = 35'(alu_x) - 35'(pab_r) - 35'(pba_r)
                               + $signed({4'b0000, qa_r});
      kaf_pkg::OP_PASS: alu_sum = 35'(alu_y);
      default:          alu_sum = 35'(alu_y);
    endcase
    alu_res = kaf_pkg::sat_s32(alu_sum);
    wdata   = wr_div ? div_quot : alu_res;
  end

  // innovation denominator s = paa + r, exact
  assign div_den = $signed({paa_r[31], paa_r}) + $signed({2'b00, rn_r});

  kaf_mulq u_mulq (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .res (mul_res)
  );

  kaf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (alu_x),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kaf_pkg::ST_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
      qa_r        <= kaf_pkg::ANGLE_NOISE_RST;
      qb_r        <= kaf_pkg::BIAS_NOISE_RST;
      rn_r        <= kaf_pkg::MEASURE_NOISE_RST;
      dt_r        <= kaf_pkg::STEP_TIME_RST;
      ang_r       <= 32'sd0;
      bias_r      <= 32'sd0;
      paa_r       <= 32'sd0;
      pab_r       <= 32'sd0;
      pba_r       <= 32'sd0;
      pbb_r       <= 32'sd0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;

      // config writes, unknown index ignored
      if (cfg_we) begin
        case (cfg_index)
          kaf_pkg::CFG_ANGLE_NOISE:   qa_r <= cfg_wdata;
          kaf_pkg::CFG_BIAS_NOISE:    qb_r <= cfg_wdata;
          kaf_pkg::CFG_MEASURE_NOISE: rn_r <= cfg_wdata;
          kaf_pkg::CFG_STEP_TIME:     dt_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (accept) begin
        mang_r  <= in_data.measured_angle;
        mrate_r <= in_data.measured_rate;
      end

      if (wr_en) begin
        case (uop.dest)
          kaf_pkg::SRC_ANG:  ang_r  <= wdata;
          kaf_pkg::SRC_BIAS: bias_r <= wdata;
          kaf_pkg::SRC_PAA:  paa_r  <= wdata;
          kaf_pkg::SRC_PAB:  pab_r  <= wdata;
          kaf_pkg::SRC_PBA:  pba_r  <= wdata;
          kaf_pkg::SRC_PBB:  pbb_r  <= wdata;
          kaf_pkg::SRC_RATE: rate_r <= wdata;
          kaf_pkg::SRC_DP:   dp_r   <= wdata;
          kaf_pkg::SRC_T:    t_r    <= wdata;
          kaf_pkg::SRC_K0:   k0_r   <= wdata;
          kaf_pkg::SRC_K1:   k1_r   <= wdata;
          kaf_pkg::SRC_Y:    y_r    <= wdata;
          default: ;
        endcase
      end

      // result item held until taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.filtered_angle <= ang_r;
      out_data_r.bias_estimate  <= bias_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/kaf_checker.sv
// ----------------------------------------------------------------------------
// kaf_checker
// port-level checks of the angle filter, bound to the top level
// ----------------------------------------------------------------------------
module kaf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input kaf_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input kaf_pkg::out_item_t out_data
);

  // an offered input item holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input item changed while waiting");

  // a waiting result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // an accepted item keeps the block busy, input is not ready again straight away
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input taken again too early");

  // a new result only appears at the end of an item's work
  a_rose: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result item without work");

  // reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("not idle after reset");

endmodule

bind kalman_angle_filter_unit kaf_checker u_kaf_checker (.*);

FILE: tb/kaf_track_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kaf_track_checker
// follows the angle filter's channels and configuration writes, runs its own
// fixed-point copy of the angle and bias filter for every accepted input item
// and compares each accepted result with the oldest estimate still owed
// ----------------------------------------------------------------------------
module kaf_track_checker
  import kaf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  input  logic      cfg_we,
  input  logic [3:0] cfg_index,
  input  logic [30:0] cfg_wdata,
  output int        fail_count,
  output int        outstanding
);

  // filter settings as last written
  logic [30:0] q_angle;
  logic [30:0] q_bias;
  logic [30:0] r_meas;
  logic [30:0] dt_step;

  // estimates (q16.16) and error covariance (q2.30)
  logic signed [31:0] ang;
  logic signed [31:0] bias;
  logic signed [31:0] paa;
  logic signed [31:0] pab;
  logic signed [31:0] pba;
  logic signed [31:0] pbb;

  out_item_t owed_estimates[$];
  out_item_t owed;
  int        errs = 0;

  assign fail_count = errs;

  function automatic logic signed [31:0] clamp32(input longint v);
    logic signed [31:0] res;
    if (v > longint'(S32_MAX)) begin
      res = S32_MAX;
    end else if (v < longint'(S32_MIN)) begin
      res = S32_MIN;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // q2.30 product, rounded half up, then clamped
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b) + HALF_Q30;
    return clamp32(p >>> 30);
  endfunction

  // num / den in q2.30, truncated toward zero; a zero denominator gives no gain
  function automatic logic signed [31:0] qgain(input logic signed [31:0] num,
                                               input longint den);
    logic signed [31:0] res;
    if (den == 0) begin
      res = '0;
    end else begin
      res = clamp32((longint'(num) <<< 30) / den);
    end
    return res;
  endfunction

  // one predict / gain / correct pass, updates the filter state
  function automatic out_item_t filter_update(input in_item_t it);
    logic signed [31:0] dt;
    logic signed [31:0] qa;
    logic signed [31:0] qb;
    logic signed [31:0] rate;
    logic signed [31:0] t;
    logic signed [31:0] dp;
    logic signed [31:0] k0;
    logic signed [31:0] k1;
    logic signed [31:0] y;
    logic signed [31:0] p00;
    logic signed [31:0] p01;
    longint             s;
    out_item_t          res;
    dt = {1'b0, dt_step};
    qa = {1'b0, q_angle};
    qb = {1'b0, q_bias};

    rate = clamp32(longint'(it.measured_rate) - longint'(bias));
    ang  = clamp32(longint'(ang) + longint'(qmul(dt, rate)));
    t    = clamp32(longint'(qmul(dt, pbb)) - longint'(pab) - longint'(pba) + longint'(qa));
    paa  = clamp32(longint'(paa) + longint'(qmul(dt, t)));
    dp   = qmul(dt, pbb);
    pab  = clamp32(longint'(pab) - longint'(dp));
    pba  = clamp32(longint'(pba) - longint'(dp));
    pbb  = clamp32(longint'(pbb) + longint'(qmul(qb, dt)));

    s  = longint'(paa) + longint'({1'b0, r_meas});
    k0 = qgain(paa, s);
    k1 = qgain(pba, s);

    y    = clamp32(longint'(it.measured_angle) - longint'(ang));
    ang  = clamp32(longint'(ang) + longint'(qmul(k0, y)));
    bias = clamp32(longint'(bias) + longint'(qmul(k1, y)));

    p00 = paa;
    p01 = pab;
    paa = clamp32(longint'(paa) - longint'(qmul(k0, p00)));
    pab = clamp32(longint'(pab) - longint'(qmul(k0, p01)));
    pba = clamp32(longint'(pba) - longint'(qmul(k1, p00)));
    pbb = clamp32(longint'(pbb) - longint'(qmul(k1, p01)));

    res.filtered_angle = ang;
    res.bias_estimate  = bias;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      q_angle = ANGLE_NOISE_RST;
      q_bias  = BIAS_NOISE_RST;
      r_meas  = MEASURE_NOISE_RST;
      dt_step = STEP_TIME_RST;
      ang     = '0;
      bias    = '0;
      paa     = '0;
      pab     = '0;
      pba     = '0;
      pbb     = '0;
      owed_estimates.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ANGLE_NOISE:   q_angle = cfg_wdata;
          CFG_BIAS_NOISE:    q_bias  = cfg_wdata;
          CFG_MEASURE_NOISE: r_meas  = cfg_wdata;
          CFG_STEP_TIME:     dt_step = cfg_wdata;
          default: ;
        endcase
      end
      // results first, so a result can never pair with the item taken at its edge
      if (out_valid && out_ready) begin
        if (owed_estimates.size() == 0) begin
          $display("%0t unexpected result: expected none, got angle %0d bias %0d", $time,
                   out_data.filtered_angle, out_data.bias_estimate);
          errs++;
        end else begin
          owed = owed_estimates.pop_front();
          if (out_data.filtered_angle !== owed.filtered_angle) begin
            $display("%0t filtered_angle mismatch: expected %0d, got %0d", $time,
                     owed.filtered_angle, out_data.filtered_angle);
            errs++;
          end
          if (out_data.bias_estimate !== owed.bias_estimate) begin
            $display("%0t bias_estimate mismatch: expected %0d, got %0d", $time,
                     owed.bias_estimate, out_data.bias_estimate);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        owed_estimates.push_back(filter_update(in_data));
      end
    end
    outstanding <= owed_estimates.size();
  end

endmodule

FILE: tb/tb_kalman_angle_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kalman_angle_filter_unit
// drives the angle filter with directed corner readings and long runs of
// random sensor readings under several noise and step time settings, with
// random idling on both channels; a checker beside the block predicts and
// compares every result, this module only makes stimulus and gives the verdict
// ----------------------------------------------------------------------------
module tb_kalman_angle_filter_unit;
  import kaf_pkg::*;

  localparam int NUM_REGS     = 4;           // indexes from here up are unused
  localparam int ITEMS_PER_PH = 85;          // random items in each phase
  localparam int HOLD_CYCLES  = 400;         // long receiver hold-off, several results long
  localparam int TAIL_CYCLES  = 200;         // worst-case latency plus margin
  localparam int WALK         = 2 << 16;     // 2 deg random walk of the true angle
  localparam int ANGLE_SPAN   = 90 << 16;    // true angle kept within +-90 deg
  localparam int NOISE        = 1 << 16;     // 1 deg accelerometer noise
  localparam int RATE_SPAN    = 250 << 16;   // gyro range +-250 deg/s
  localparam logic [30:0] REG_MAX = '1;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we    = 1'b0;
  logic [3:0] cfg_index = '0;
  logic [30:0] cfg_wdata = '0;

  int fail_count;
  int outstanding;

  // idle odds in percent for each side
  int send_idle_pct = 37;
  int recv_idle_pct = 47;

  // long hold-off requests from the stimulus, served by the receiver process
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // slowly moving true angle behind the realistic readings
  int track_angle = 0;

  kalman_angle_filter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  kaf_track_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, plus a counted long hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("FAIL kalman_angle_filter_unit");
    $finish;
  end

  function automatic logic signed [31:0] corner_value();
    logic signed [31:0] v;
    case ($urandom_range(4))
      0:       v = S32_MAX;
      1:       v = S32_MIN;
      2:       v = '0;
      3:       v = -32'sd1;
      default: v = 32'sd1;
    endcase
    return v;
  endfunction

  function automatic in_item_t reading(input logic signed [31:0] angle,
                                       input logic signed [31:0] rate);
    in_item_t it;
    it.measured_angle = angle;
    it.measured_rate  = rate;
    return it;
  endfunction

  // mostly a plausible tilt with sensor noise, some raw random words and corners
  function automatic in_item_t next_reading();
    in_item_t it;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      track_angle = track_angle + int'($urandom_range(0, 2 * WALK)) - WALK;
      if (track_angle > ANGLE_SPAN) track_angle = ANGLE_SPAN;
      if (track_angle < -ANGLE_SPAN) track_angle = -ANGLE_SPAN;
      it.measured_angle = track_angle + int'($urandom_range(0, 2 * NOISE)) - NOISE;
      it.measured_rate  = int'($urandom_range(0, 2 * RATE_SPAN)) - RATE_SPAN;
    end else if (pick < 85) begin
      it.measured_angle = $urandom;
      it.measured_rate  = $urandom;
    end else begin
      it.measured_angle = corner_value();
      it.measured_rate  = corner_value();
    end
    return it;
  endfunction

  // one item: optional idle gap, then hold valid until the block takes it
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering and wait until every owed result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // all four registers, then a stray write to an unused index that must be ignored
  task automatic program_regs(input logic [30:0] qa, input logic [30:0] qb,
                              input logic [30:0] r, input logic [30:0] dt);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ANGLE_NOISE;
    cfg_wdata <= qa;
    @(posedge clk);
    cfg_index <= CFG_BIAS_NOISE;
    cfg_wdata <= qb;
    @(posedge clk);
    cfg_index <= CFG_MEASURE_NOISE;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_index <= CFG_STEP_TIME;
    cfg_wdata <= dt;
    @(posedge clk);
    cfg_index <= 4'($urandom_range(15, NUM_REGS));
    cfg_wdata <= 31'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // zero noise and zero measurement noise right after reset: the covariance
    // stays zero, the gain denominator is zero and no correction happens
    program_regs('0, '0, '0, 31'($urandom_range(1, 1 << 30)));
    send_item(reading(S32_MAX, S32_MAX));
    send_item(reading(S32_MIN, S32_MIN));
    send_item(reading(S32_MAX, S32_MIN));
    send_item(reading(S32_MIN, S32_MAX));
    send_item(reading('0, '0));
    send_item(reading(-32'sd1, 32'sd1));
    drain();

    // default tuning with plausible and extreme readings
    program_regs(ANGLE_NOISE_RST, BIAS_NOISE_RST, MEASURE_NOISE_RST, STEP_TIME_RST);
    send_item(reading('0, '0));
    send_item(reading(32'sd10 <<< 16, 32'sd5 <<< 16));
    send_item(reading(-(32'sd45 <<< 16), -(32'sd100 <<< 16)));
    send_item(reading(S32_MAX, '0));
    send_item(reading(S32_MIN, '0));
    send_item(reading('0, S32_MAX));
    send_item(reading('0, S32_MIN));
    drain();

    // zero step time freezes the prediction; smallest nonzero measurement noise
    program_regs(ANGLE_NOISE_RST, BIAS_NOISE_RST, 31'd1, '0);
    send_item(reading(32'sd20 <<< 16, 32'sd50 <<< 16));
    send_item(reading(S32_MAX, S32_MAX));
    send_item(reading(S32_MIN, -32'sd1));
    drain();

    // random phases: idle pattern changes every two phases, settings every phase
    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 37 : (ph < 4) ? 47 : 0;
      recv_idle_pct = (ph < 2) ? 47 : (ph < 4) ? 37 : 0;
      case (ph)
        0, 1, 3: begin
          // plausible tuning
          program_regs(31'($urandom_range(0, 1 << 22)), 31'($urandom_range(0, 1 << 22)),
                       31'($urandom_range(1, 1 << 27)), 31'($urandom_range(1, 1 << 25)));
        end
        2: begin
          // raw random register words
          program_regs(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
        end
        4: begin
          // every register at its top value
          program_regs(REG_MAX, REG_MAX, REG_MAX, REG_MAX);
        end
        default: begin
          // each register at zero, one or its top value
          program_regs($urandom_range(1) ? REG_MAX : 31'($urandom_range(1)),
                       $urandom_range(1) ? REG_MAX : 31'($urandom_range(1)),
                       $urandom_range(1) ? REG_MAX : 31'($urandom_range(1)),
                       $urandom_range(1) ? REG_MAX : 31'($urandom_range(1)));
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PH; n++) begin
        // receiver stops for a long while, sender keeps offering so input backs up
        if (ph == 1 && n == 20) hold_req = hold_req + 1;
        // sender pauses until the block has returned everything
        if (ph == 3 && n == 40) drain();
        send_item(next_reading());
      end
      drain();
    end

    // let anything late or stray show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS kalman_angle_filter_unit");
    end else begin
      $display("FAIL kalman_angle_filter_unit");
    end
    $finish;
  end

endmodule
